@@ design/jog_shuttle_report_decoder_top_defines.svh @@
// ----------------------------------------------------------------------------
// Jog/shuttle report decoder - assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef JOG_SHUTTLE_REPORT_DECODER_TOP_DEFINES_SVH
`define JOG_SHUTTLE_REPORT_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, quiet while reset is asserted
`define JSRD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Check a property on every rising edge, reset cycles included
`define JSRD_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define JSRD_ASSERT(label, clk, rst_n, prop, msg)
`define JSRD_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

@@ design/jsrd_pkg.sv @@
// ----------------------------------------------------------------------------
// Jog/shuttle report decoder - package
// Widths, event kinds, slot positions and the decode hand-off structure.
// ----------------------------------------------------------------------------
package jsrd_pkg;

    // Field widths
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 16;
    localparam int KIND_W      = 2;
    localparam int CODE_W      = 4;
    localparam int VALUE_W     = 8;
    localparam int BUTTON_BITS = 13;

    // Parameter defaults
    localparam int NUM_BUTTONS_DEF   = 13;
    localparam int SHUTTLE_LIMIT_DEF = 7;

    // Report decoding constants
    localparam logic [7:0] MIN_REPORT = 8'd5;
    localparam logic [4:0] HIGH_MASK  = 5'h1f;

    // Event slots of one report, emitted lowest first
    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam logic [SLOT_W-1:0] SLOT_SHUTTLE = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_JOG     = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_KEY0    = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_SYNC    = 4'd15;

    typedef enum logic [KIND_W-1:0] {
        KIND_SHUTTLE = 2'd0,
        KIND_JOG     = 2'd1,
        KIND_KEY     = 2'd2,
        KIND_SYNC    = 2'd3
    } t_kind;

    // Decoded report, handed from the decoder to the emitter
    typedef struct packed {
        logic [NUM_SLOTS-1:0]   pend;
        logic signed [VALUE_W-1:0] shuttle;
        logic signed [VALUE_W-1:0] delta;
        logic [BUTTON_BITS-1:0] buttons;
    } t_decode;

endpackage

@@ design/jsrd_decode.sv @@
// ----------------------------------------------------------------------------
// Jog/shuttle report decoder - report decode
// Clamps the shuttle, forms the jog delta and button changes against the
// previous full report, and keeps that history.
// ----------------------------------------------------------------------------
module jsrd_decode #(
    parameter int NUM_BUTTONS   = jsrd_pkg::NUM_BUTTONS_DEF,
    parameter int SHUTTLE_LIMIT = jsrd_pkg::SHUTTLE_LIMIT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic signed [7:0]      i_shuttle_raw,
    input  logic [7:0]             i_jog_raw,
    input  logic [7:0]             i_buttons_low,
    input  logic [7:0]             i_buttons_high,
    input  logic [7:0]             i_report_length,
    output jsrd_pkg::t_decode      o_dec
);
    import jsrd_pkg::*;

    localparam logic signed [VALUE_W-1:0] LIM_P = VALUE_W'(SHUTTLE_LIMIT);
    localparam logic signed [VALUE_W-1:0] LIM_N = VALUE_W'(-SHUTTLE_LIMIT);
    localparam logic [BUTTON_BITS-1:0] BTN_MASK =
        BUTTON_BITS'((1 << NUM_BUTTONS) - 1);

    logic [BUTTON_BITS-1:0] r_prev_buttons;
    logic [7:0]             r_prev_jog;
    logic                   r_jog_seen;

    logic                   full_len;
    logic [7:0]             delta;
    logic                   jog_ev;
    logic [BUTTON_BITS-1:0] buttons;
    logic [BUTTON_BITS-1:0] changed;

    // Decode the incoming report against the stored history
    always_comb begin
        full_len = (i_report_length >= MIN_REPORT);
        delta    = i_jog_raw - r_prev_jog;
        jog_ev   = r_jog_seen && (delta != 8'd0);
        buttons  = {i_buttons_high[4:0] & HIGH_MASK, i_buttons_low};
        changed  = (buttons ^ r_prev_buttons) & BTN_MASK;

        if (i_shuttle_raw > LIM_P) begin
            o_dec.shuttle = LIM_P;
        end else if (i_shuttle_raw < LIM_N) begin
            o_dec.shuttle = LIM_N;
        end else begin
            o_dec.shuttle = i_shuttle_raw;
        end
        o_dec.delta   = delta;
        o_dec.buttons = buttons;
        o_dec.pend    = full_len ? {1'b1, changed, jog_ev, 1'b1} : '0;
    end

    // Hold the jog position and button levels of the last full report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons <= '0;
            r_prev_jog     <= '0;
            r_jog_seen     <= 1'b0;
        end else if (i_accept && full_len) begin
            r_prev_buttons <= buttons;
            r_prev_jog     <= i_jog_raw;
            r_jog_seen     <= 1'b1;
        end
    end

endmodule

@@ design/jog_shuttle_report_decoder_top.sv @@
// ----------------------------------------------------------------------------
// Jog/shuttle report decoder - top level
// Turns each report into a run of shuttle, jog, key and sync events.
//
//   channel  dir  tdata (low bit up)                      tuser       tlast
//   s_axis   in   shuttle_raw, jog_raw, buttons_low,      -           -
//                 buttons_high, report_length (40 bits)
//   m_axis   out  event_code, event_value, zero pad       event_kind  last_event
//
// A full report yields 2 to 16 events, one per cycle from the output register.
// The pending-event mask sets the rate: the next report is taken in the cycle
// its predecessor's sync event moves to the output register.
// Short reports produce nothing and are taken every cycle while no events are pending.
// Synchronous active-low reset clears the history, pending mask and valid.
// A stalled output holds its item; emission pauses with it.
// ----------------------------------------------------------------------------
module jog_shuttle_report_decoder_top #(
    parameter int NUM_BUTTONS   = jsrd_pkg::NUM_BUTTONS_DEF,
    parameter int SHUTTLE_LIMIT = jsrd_pkg::SHUTTLE_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // shuttle_raw[7:0], jog_raw[15:8], buttons_low[23:16],
    // buttons_high[31:24], report_length[39:32]
    input  logic [jsrd_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // event_code[3:0], event_value[11:4], zero[15:12]
    output logic [jsrd_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // event_kind[1:0]
    output logic [jsrd_pkg::KIND_W-1:0]       o_m_axis_tuser,
    // last_event
    output logic                              o_m_axis_tlast
);
    import jsrd_pkg::*;

`include "jog_shuttle_report_decoder_top_defines.svh"

    t_decode dec;

    logic s_acc;
    logic m_adv;
    logic pend_last;
    logic [7:0] s_report_length;

    logic [NUM_SLOTS-1:0]      r_pend;
    logic signed [VALUE_W-1:0] r_shuttle;
    logic signed [VALUE_W-1:0] r_delta;
    logic [BUTTON_BITS-1:0]    r_buttons;

    logic                      r_m_valid;
    t_kind                     r_kind;
    logic [CODE_W-1:0]         r_code;
    logic [VALUE_W-1:0]        r_value;
    logic                      r_last;

    logic [NUM_SLOTS-1:0]      low_bit;
    logic [SLOT_W-1:0]         sel;
    logic [CODE_W-1:0]         key_idx;
    t_kind                     n_kind;
    logic [CODE_W-1:0]         n_code;
    logic [VALUE_W-1:0]        n_value;
    logic                      n_last;

    assign s_report_length = i_s_axis_tdata[39:32];

    jsrd_decode #(
        .NUM_BUTTONS   (NUM_BUTTONS),
        .SHUTTLE_LIMIT (SHUTTLE_LIMIT)
    ) u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (s_acc),
        .i_shuttle_raw   (i_s_axis_tdata[7:0]),
        .i_jog_raw       (i_s_axis_tdata[15:8]),
        .i_buttons_low   (i_s_axis_tdata[23:16]),
        .i_buttons_high  (i_s_axis_tdata[31:24]),
        .i_report_length (s_report_length),
        .o_dec           (dec)
    );

    // Handshakes: take a report once the current one is drained
    assign m_adv           = !r_m_valid || i_m_axis_tready;
    assign pend_last       = ((r_pend & (r_pend - 1'b1)) == '0);
    assign o_s_axis_tready = (r_pend == '0) || (pend_last && m_adv);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // Pick the lowest pending event slot
    always_comb begin
        low_bit = r_pend & (~r_pend + 1'b1);
        sel     = SLOT_SYNC;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                sel = SLOT_W'(i);
            end
        end
    end

    // Form the event for the selected slot
    always_comb begin
        key_idx = sel - SLOT_KEY0;
        n_code  = '0;
        n_value = '0;
        n_last  = 1'b0;
        case (sel)
            SLOT_SHUTTLE: begin
                n_kind  = KIND_SHUTTLE;
                n_value = r_shuttle;
            end
            SLOT_JOG: begin
                n_kind  = KIND_JOG;
                n_value = r_delta;
            end
            SLOT_SYNC: begin
                n_kind  = KIND_SYNC;
                n_last  = 1'b1;
            end
            default: begin
                n_kind  = KIND_KEY;
                n_code  = key_idx;
                n_value = {7'd0, r_buttons[key_idx]};
            end
        endcase
    end

    // Advance the pending mask and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (m_adv) begin
                r_m_valid <= (r_pend != '0);
            end
            if (s_acc) begin
                r_pend <= dec.pend;
            end else if (m_adv) begin
                r_pend <= r_pend & ~low_bit;
            end
        end
    end

    // Hold the decoded report while its events drain
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_shuttle <= dec.shuttle;
            r_delta   <= dec.delta;
            r_buttons <= dec.buttons;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (m_adv && (r_pend != '0)) begin
            r_kind  <= n_kind;
            r_code  <= n_code;
            r_value <= n_value;
            r_last  <= n_last;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {4'd0, r_value, r_code};
    assign o_m_axis_tuser  = r_kind;
    assign o_m_axis_tlast  = r_last;

    `JSRD_ASSERT(a_last_on_sync, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser == KIND_SYNC)), "tlast does not match a sync event")
    `JSRD_ASSERT(a_sync_pending, i_clk, i_rst_n, (r_pend != '0) |-> r_pend[SLOT_SYNC], "pending events without a closing sync")
    `JSRD_ASSERT(a_full_report_queues, i_clk, i_rst_n, (s_acc && (s_report_length >= MIN_REPORT)) |=> (r_pend[SLOT_SHUTTLE] && r_pend[SLOT_SYNC]), "full report did not queue shuttle and sync")
    `JSRD_ASSERT_NR(a_reset_clears, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule
